### rtl/core/dapc_pkg.sv
// ============================================================================
// dapc_pkg: shared types and constants of the dual-axis PID controller
// Field widths, fixed-point constants, register indexes and sequencer states.
// ============================================================================
package dapc_pkg;

  // Field widths
  localparam int ANGLE_WIDTH = 16;
  localparam int ERR_W       = ANGLE_WIDTH + 1;
  localparam int GAIN_W      = 24;
  localparam int DT_W        = 20;
  localparam int DRIVE_W     = 16;
  localparam int INTEG_W     = 48;
  localparam int CFG_IDX_W   = 3;

  // Datapath widths
  localparam int SUM_W     = 64;
  localparam int MUL_A_W   = 24;
  localparam int MUL_B_W   = (ERR_W > 32) ? ERR_W : 32;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int TOT_W     = PROD_W + MUL_B_W;
  localparam int DERIV_W   = ANGLE_WIDTH + 21;
  localparam int DIV_RAW_W = (DERIV_W > INTEG_W) ? DERIV_W : INTEG_W;
  localparam int DIV_N_W   = DIV_RAW_W + (DIV_RAW_W % 2);
  localparam int DIV_D_W   = 30;
  localparam int IQ_W      = 28;
  localparam int IR_W      = 20;
  localparam int SM_W      = 30;

  // Fixed-point constants
  localparam logic [DIV_D_W-1:0] USEC_PER_SEC = 30'd1000000;
  localparam logic [DIV_D_W-1:0] LIMIT_Q24    = 30'(45 << 24);
  localparam logic [MUL_A_W-1:0] DRIVE_FULL   = 24'd32767;
  localparam logic [TOT_W-1:0]   D_SAT        = TOT_W'(64'd1 << 61);

  // Gain reset values (Q8.16)
  localparam logic signed [GAIN_W-1:0] KP_RESET = 24'sd65536;
  localparam logic signed [GAIN_W-1:0] KI_RESET = 24'sd6554;
  localparam logic signed [GAIN_W-1:0] KD_RESET = 24'sd3277;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_KP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_KI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_KD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_KP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_KI = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_KD = 3'd5;

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] roll_angle;
    logic signed [ANGLE_WIDTH-1:0] pitch_angle;
    logic signed [ANGLE_WIDTH-1:0] roll_target;
    logic signed [ANGLE_WIDTH-1:0] pitch_target;
    logic        [DT_W-1:0]        delta_us;
  } sample_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] roll_drive;
    logic signed [DRIVE_W-1:0] pitch_drive;
  } drive_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ERR,
    ST_PMUL,
    ST_PSUM,
    ST_IACC,
    ST_DDIV,
    ST_DWAIT,
    ST_DLO,
    ST_DHI,
    ST_DSUM,
    ST_IDIV,
    ST_IWAIT,
    ST_ILO,
    ST_IHI,
    ST_IDIV2,
    ST_IWAIT2,
    ST_CLAMP,
    ST_OMUL,
    ST_ODIV,
    ST_OWAIT,
    ST_DONE
  } state_t;

endpackage

### rtl/core/dapc_divider.sv
// ============================================================================
// dapc_divider: shared unsigned restoring divider
// Two quotient bits per cycle; done pulses once quotient and remainder hold.
// ============================================================================
module dapc_divider #(
  parameter int DIVIDEND_W = dapc_pkg::DIV_N_W,
  parameter int DIVISOR_W  = dapc_pkg::DIV_D_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int STEPS = DIVIDEND_W / 2;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic                  running;
  logic [CNT_W-1:0]      cnt;
  logic [DIVIDEND_W-1:0] quo, quo_next;
  logic [DIVISOR_W-1:0]  rem, rem_next, dsr;
  logic [DIVISOR_W:0]    s1, s2;

  // One restoring step: shift in a dividend bit, subtract if it fits
  function automatic logic [DIVISOR_W:0] div_step(input logic [DIVISOR_W-1:0] r,
                                                  input logic b,
                                                  input logic [DIVISOR_W-1:0] d);
    logic [DIVISOR_W:0] sh;
    logic [DIVISOR_W:0] diff;
    sh   = {r, b};
    diff = sh - {1'b0, d};
    if (sh >= {1'b0, d}) begin
      return {diff[DIVISOR_W-1:0], 1'b1};
    end
    return {sh[DIVISOR_W-1:0], 1'b0};
  endfunction

  // Two chained steps per cycle
  always_comb begin
    s1       = div_step(rem, quo[DIVIDEND_W-1], dsr);
    s2       = div_step(s1[DIVISOR_W:1], quo[DIVIDEND_W-2], dsr);
    rem_next = s2[DIVISOR_W:1];
    quo_next = {quo[DIVIDEND_W-3:0], s1[0], s2[0]};
  end

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Load operands, then advance remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (running) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### rtl/core/dual_axis_pid_controller.sv
// ============================================================================
// dual_axis_pid_controller: roll and pitch PID attitude controller
// Fixed-point PID per axis with saturating integral, derivative over elapsed
// time and a clamped, normalized Q1.15 drive; one shared multiplier and one
// shared divider run under a small sequencer.
// ============================================================================
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  sample   | sample_valid/_stall  | angles, targets, delta_us
//  drive    | drive_valid/_stall   | roll_drive, pitch_drive
//  cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data (gains, Q8.16)
//
// The shared divider sets the pace of a request: up to four divisions per axis
// (three with zero elapsed time), two quotient bits per cycle, and the axes
// run one after the other.
// Reset clears integrals and last errors and loads default gains.
// The next request is taken while a finished result still waits on a stalled
// drive channel; a second result waits in the sequencer until the first goes.
// cfg_ready stays high; writes to indexes above five are dropped.
module dual_axis_pid_controller (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  dapc_pkg::sample_t                  sample,
  output logic                               drive_valid,
  input  logic                               drive_stall,
  output dapc_pkg::drive_t                   drive,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dapc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dapc_pkg::GAIN_W-1:0]        cfg_data
);

  import dapc_pkg::*;

  localparam logic signed [SUM_W-1:0] INT_MAX   = (64'sd1 <<< (INTEG_W - 1)) - 64'sd1;
  localparam logic signed [SUM_W-1:0] INT_MIN   = -(64'sd1 <<< (INTEG_W - 1));
  localparam logic signed [SUM_W-1:0] LIMIT_POS = $signed(SUM_W'(LIMIT_Q24));
  localparam logic signed [SUM_W-1:0] LIMIT_NEG = -LIMIT_POS;

  // Sequencer and request
  state_t  state, state_next;
  logic    ax;
  sample_t req;

  // Gains and per-axis state
  logic signed [GAIN_W-1:0]  kp [2];
  logic signed [GAIN_W-1:0]  ki [2];
  logic signed [GAIN_W-1:0]  kd [2];
  logic signed [INTEG_W-1:0] integral [2];
  logic signed [ERR_W-1:0]   last_err [2];

  // Working registers
  logic [ERR_W-1:0]          errm, dem;
  logic                      err_neg, de_neg;
  logic [PROD_W-1:0]         prod, part;
  logic [DERIV_W-1:0]        deriv;
  logic [IQ_W-1:0]           iq;
  logic [IR_W-1:0]           ir;
  logic signed [SUM_W-1:0]   sum;
  logic [SM_W-1:0]           sm;
  logic                      out_neg;
  logic signed [DRIVE_W-1:0] roll_drv, pitch_drv;

  // Shared units
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               div_start, div_done;
  logic [DIV_N_W-1:0] div_dividend, div_quo;
  logic [DIV_D_W-1:0] div_divisor, div_rem;

  // Handshake controls
  logic accept, out_load;

  // Combinational datapath values
  logic signed [ANGLE_WIDTH-1:0] ang, tgt;
  logic signed [ERR_W-1:0]       err_n;
  logic signed [ERR_W:0]         de_n;
  logic [ERR_W-1:0]              errm_n, dem_n;
  logic [GAIN_W-1:0]             kpm, kim, kdm;
  logic [INTEG_W-1:0]            im;
  logic signed [SUM_W-1:0]       inc, acc, acc_sat;
  logic [TOT_W-1:0]              tot, dm;
  logic [SUM_W-1:0]              itm;
  logic signed [SUM_W-1:0]       cs;
  logic signed [DRIVE_W-1:0]     drv_n;

  assign cfg_ready = 1'b1;

  // Form errors, magnitudes and the term arithmetic
  always_comb begin
    ang    = ax ? req.pitch_angle : req.roll_angle;
    tgt    = ax ? req.pitch_target : req.roll_target;
    err_n  = {tgt[ANGLE_WIDTH-1], tgt} - {ang[ANGLE_WIDTH-1], ang};
    de_n   = {err_n[ERR_W-1], err_n} - {last_err[ax][ERR_W-1], last_err[ax]};
    errm_n = err_n[ERR_W-1] ? -err_n : err_n;
    dem_n  = ERR_W'(de_n[ERR_W] ? -de_n : de_n);
    kpm    = kp[ax][GAIN_W-1] ? -kp[ax] : kp[ax];
    kim    = ki[ax][GAIN_W-1] ? -ki[ax] : ki[ax];
    kdm    = kd[ax][GAIN_W-1] ? -kd[ax] : kd[ax];
    im     = integral[ax][INTEG_W-1] ? -integral[ax] : integral[ax];

    // Integral update with saturation at 48 bits
    inc = err_neg ? -$signed(SUM_W'(prod)) : $signed(SUM_W'(prod));
    acc = SUM_W'(integral[ax]) + inc;
    if (acc > INT_MAX) begin
      acc_sat = INT_MAX;
    end else if (acc < INT_MIN) begin
      acc_sat = INT_MIN;
    end else begin
      acc_sat = acc;
    end

    // Derivative product from two partial products, capped
    tot = (TOT_W'(prod) << MUL_B_W) + TOT_W'(part);
    dm  = (tot > D_SAT) ? D_SAT : tot;

    // Integral term: whole part plus fractional part
    itm = SUM_W'(part) + SUM_W'(div_quo);

    // Clamp the sum to +/-45 degrees
    if (sum > LIMIT_POS) begin
      cs = LIMIT_POS;
    end else if (sum < LIMIT_NEG) begin
      cs = LIMIT_NEG;
    end else begin
      cs = sum;
    end

    drv_n = out_neg ? -$signed(DRIVE_W'(div_quo)) : $signed(DRIVE_W'(div_quo));
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, unit operands and handshake controls
  always_comb begin
    state_next   = state;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    sample_stall = 1'b1;
    accept       = 1'b0;
    out_load     = 1'b0;
    case (state)
      ST_IDLE: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          accept     = 1'b1;
          state_next = ST_ERR;
        end
      end
      ST_ERR: begin
        state_next = ST_PMUL;
      end
      ST_PMUL: begin
        mul_a      = kpm;
        mul_b      = MUL_B_W'(errm);
        state_next = ST_PSUM;
      end
      ST_PSUM: begin
        mul_a      = MUL_A_W'(req.delta_us);
        mul_b      = MUL_B_W'(errm);
        state_next = (req.delta_us == '0) ? ST_IDIV : ST_IACC;
      end
      ST_IACC: begin
        mul_a      = MUL_A_W'(USEC_PER_SEC);
        mul_b      = MUL_B_W'(dem);
        state_next = ST_DDIV;
      end
      ST_DDIV: begin
        div_start    = 1'b1;
        div_dividend = DIV_N_W'(prod);
        div_divisor  = DIV_D_W'(req.delta_us);
        state_next   = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          state_next = ST_DLO;
        end
      end
      ST_DLO: begin
        mul_a      = kdm;
        mul_b      = deriv[MUL_B_W-1:0];
        state_next = ST_DHI;
      end
      ST_DHI: begin
        mul_a      = kdm;
        mul_b      = MUL_B_W'(deriv >> MUL_B_W);
        state_next = ST_DSUM;
      end
      ST_DSUM: begin
        state_next = ST_IDIV;
      end
      ST_IDIV: begin
        div_start    = 1'b1;
        div_dividend = DIV_N_W'(im);
        div_divisor  = USEC_PER_SEC;
        state_next   = ST_IWAIT;
      end
      ST_IWAIT: begin
        if (div_done) begin
          state_next = ST_ILO;
        end
      end
      ST_ILO: begin
        mul_a      = kim;
        mul_b      = MUL_B_W'(iq);
        state_next = ST_IHI;
      end
      ST_IHI: begin
        mul_a      = kim;
        mul_b      = MUL_B_W'(ir);
        state_next = ST_IDIV2;
      end
      ST_IDIV2: begin
        div_start    = 1'b1;
        div_dividend = DIV_N_W'(prod);
        div_divisor  = USEC_PER_SEC;
        state_next   = ST_IWAIT2;
      end
      ST_IWAIT2: begin
        if (div_done) begin
          state_next = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        state_next = ST_OMUL;
      end
      ST_OMUL: begin
        mul_a      = DRIVE_FULL;
        mul_b      = MUL_B_W'(sm);
        state_next = ST_ODIV;
      end
      ST_ODIV: begin
        div_start    = 1'b1;
        div_dividend = DIV_N_W'(prod) + DIV_N_W'(LIMIT_Q24 >> 1);
        div_divisor  = LIMIT_Q24;
        state_next   = ST_OWAIT;
      end
      ST_OWAIT: begin
        if (div_done) begin
          state_next = ax ? ST_DONE : ST_ERR;
        end
      end
      ST_DONE: begin
        if (!drive_valid || !drive_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Shared divider
  dapc_divider #(
    .DIVIDEND_W (DIV_N_W),
    .DIVISOR_W  (DIV_D_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kp[0] <= KP_RESET;
      ki[0] <= KI_RESET;
      kd[0] <= KD_RESET;
      kp[1] <= KP_RESET;
      ki[1] <= KI_RESET;
      kd[1] <= KD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROLL_KP:  kp[0] <= cfg_data;
        CFG_ROLL_KI:  ki[0] <= cfg_data;
        CFG_ROLL_KD:  kd[0] <= cfg_data;
        CFG_PITCH_KP: kp[1] <= cfg_data;
        CFG_PITCH_KI: ki[1] <= cfg_data;
        CFG_PITCH_KD: kd[1] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-axis state: integral and last error
  always_ff @(posedge clk) begin
    if (rst) begin
      integral[0] <= '0;
      integral[1] <= '0;
      last_err[0] <= '0;
      last_err[1] <= '0;
    end else begin
      if (state == ST_ERR) begin
        last_err[ax] <= err_n;
      end
      if (state == ST_IACC) begin
        integral[ax] <= acc_sat[INTEG_W-1:0];
      end
    end
  end

  // Axis select
  always_ff @(posedge clk) begin
    if (rst) begin
      ax <= 1'b0;
    end else if (accept) begin
      ax <= 1'b0;
    end else if (state == ST_OWAIT && div_done) begin
      ax <= 1'b1;
    end
  end

  // Working registers of the sequence
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= sample;
    end
    case (state)
      ST_ERR: begin
        errm    <= errm_n;
        err_neg <= err_n[ERR_W-1];
        dem     <= dem_n;
        de_neg  <= de_n[ERR_W];
      end
      ST_PSUM: begin
        sum <= (err_neg ^ kp[ax][GAIN_W-1]) ? -$signed(SUM_W'(prod))
                                            : $signed(SUM_W'(prod));
      end
      ST_DWAIT: begin
        if (div_done) begin
          deriv <= DERIV_W'(div_quo);
        end
      end
      ST_DHI: begin
        part <= prod;
      end
      ST_DSUM: begin
        sum <= (de_neg ^ kd[ax][GAIN_W-1]) ? sum - $signed(SUM_W'(dm))
                                           : sum + $signed(SUM_W'(dm));
      end
      ST_IWAIT: begin
        if (div_done) begin
          iq <= IQ_W'(div_quo);
          ir <= IR_W'(div_rem);
        end
      end
      ST_IHI: begin
        part <= prod;
      end
      ST_IWAIT2: begin
        if (div_done) begin
          sum <= (integral[ax][INTEG_W-1] ^ ki[ax][GAIN_W-1]) ? sum - $signed(itm)
                                                              : sum + $signed(itm);
        end
      end
      ST_CLAMP: begin
        sm      <= SM_W'(cs[SUM_W-1] ? -cs : cs);
        out_neg <= cs[SUM_W-1];
      end
      ST_OWAIT: begin
        if (div_done) begin
          if (ax) begin
            pitch_drv <= drv_n;
          end else begin
            roll_drv <= drv_n;
          end
        end
      end
      default: ;
    endcase
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_valid <= 1'b0;
    end else if (out_load) begin
      drive_valid <= 1'b1;
    end else if (drive_valid && !drive_stall) begin
      drive_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      drive.roll_drive  <= roll_drv;
      drive.pitch_drive <= pitch_drv;
    end
  end

endmodule

### dv/pid_drive_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// pid_drive_checker: drive predictor and scoreboard for the PID controller
// Watches the sample, drive and gain-write channels. Every accepted sample
// request is run through a bit-exact model of both axes, and the predicted
// drives are compared in order, field by field, with the drive channel.
// ============================================================================
module pid_drive_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  input  logic                           sample_stall,
  input  dapc_pkg::sample_t              sample,
  input  logic                           drive_valid,
  input  logic                           drive_stall,
  input  dapc_pkg::drive_t               drive,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [dapc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dapc_pkg::GAIN_W-1:0]    cfg_data,
  output int                             fail_count,
  output int                             pending
);

  import dapc_pkg::*;

  typedef longint unsigned u64_t;

  localparam longint INTEG_HI   = (longint'(1) <<< 47) - 1;
  localparam longint INTEG_LO   = -(longint'(1) <<< 47);
  localparam longint SUM_LIMIT  = longint'(45) <<< 24;
  localparam u64_t   FULL_Q24   = 64'd45 << 24;
  localparam u64_t   MICROS     = 64'd1000000;
  localparam u64_t   DERIV_SAT  = 64'd1 << 61;
  localparam u64_t   FULL_SCALE = 64'd32767;

  // Per-axis gains and state, index 0 is roll, 1 is pitch
  longint kp_gain [2];
  longint ki_gain [2];
  longint kd_gain [2];
  longint integ [2];
  longint last_err [2];

  drive_t expected_drives [$];
  int     drives_seen;

  function automatic u64_t abs_val(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint with_sign(input bit neg, input u64_t m);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // Advance one axis by one sample and return its Q1.15 drive
  function automatic logic signed [DRIVE_W-1:0] predict_axis_drive(
    input int ax, input longint angle, input longint target, input u64_t dt);
    longint err, p_term, i_term, d_term, acc, de, sum;
    u64_t   deriv, kd_mag, d_mag, i_mag, ki_mag, i_whole, i_frac, i_out, o_mag;
    err    = target - angle;
    p_term = kp_gain[ax] * err;
    d_term = 0;
    // Integrate and differentiate only when time has passed
    if (dt != 0) begin
      acc = integ[ax] + err * longint'(dt);
      if (acc > INTEG_HI) acc = INTEG_HI;
      if (acc < INTEG_LO) acc = INTEG_LO;
      integ[ax] = acc;
      de     = err - last_err[ax];
      deriv  = abs_val(de) * MICROS / dt;
      kd_mag = abs_val(kd_gain[ax]);
      if (kd_mag != 0 && deriv > DERIV_SAT / kd_mag) d_mag = DERIV_SAT;
      else d_mag = kd_mag * deriv;
      d_term = with_sign((de < 0) != (kd_gain[ax] < 0), d_mag);
    end
    // Split the integral so the product stays within 64 bits
    i_mag   = abs_val(integ[ax]);
    ki_mag  = abs_val(ki_gain[ax]);
    i_whole = i_mag / MICROS;
    i_frac  = i_mag % MICROS;
    i_out   = ki_mag * i_whole + (ki_mag * i_frac) / MICROS;
    i_term  = with_sign((integ[ax] < 0) != (ki_gain[ax] < 0), i_out);
    last_err[ax] = err;
    // Clamp to 45 degrees and scale with round half away from zero
    sum = p_term + i_term + d_term;
    if (sum > SUM_LIMIT) sum = SUM_LIMIT;
    if (sum < -SUM_LIMIT) sum = -SUM_LIMIT;
    o_mag = (abs_val(sum) * FULL_SCALE + FULL_Q24 / 2) / FULL_Q24;
    return DRIVE_W'(with_sign(sum < 0, o_mag));
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("[%0t] drive check: %s", $time, what);
  endtask

  always @(posedge clk) begin
    drive_t want;
    if (rst) begin
      for (int ax = 0; ax < 2; ax++) begin
        kp_gain[ax]  = KP_RESET;
        ki_gain[ax]  = KI_RESET;
        kd_gain[ax]  = KD_RESET;
        integ[ax]    = 0;
        last_err[ax] = 0;
      end
      expected_drives.delete();
      drives_seen = 0;
    end else begin
      // Compare a finished drive with the oldest prediction
      if (drive_valid && !drive_stall) begin
        drives_seen++;
        if (expected_drives.size() == 0) begin
          report_mismatch($sformatf("drive #%0d (%h) with no request pending",
                                    drives_seen, drive));
        end else begin
          want = expected_drives.pop_front();
          if (drive.roll_drive !== want.roll_drive)
            report_mismatch($sformatf("drive #%0d roll_drive %0d, want %0d",
                                      drives_seen, drive.roll_drive, want.roll_drive));
          if (drive.pitch_drive !== want.pitch_drive)
            report_mismatch($sformatf("drive #%0d pitch_drive %0d, want %0d",
                                      drives_seen, drive.pitch_drive, want.pitch_drive));
        end
      end
      // Track gain writes, drop unmapped indexes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROLL_KP:  kp_gain[0] = $signed(cfg_data);
          CFG_ROLL_KI:  ki_gain[0] = $signed(cfg_data);
          CFG_ROLL_KD:  kd_gain[0] = $signed(cfg_data);
          CFG_PITCH_KP: kp_gain[1] = $signed(cfg_data);
          CFG_PITCH_KI: ki_gain[1] = $signed(cfg_data);
          CFG_PITCH_KD: kd_gain[1] = $signed(cfg_data);
          default: ;
        endcase
      end
      // Predict both drives of an accepted request
      if (sample_valid && !sample_stall) begin
        want.roll_drive  = predict_axis_drive(0, $signed(sample.roll_angle),
                                              $signed(sample.roll_target),
                                              sample.delta_us);
        want.pitch_drive = predict_axis_drive(1, $signed(sample.pitch_angle),
                                              $signed(sample.pitch_target),
                                              sample.delta_us);
        expected_drives.push_back(want);
      end
    end
    pending = expected_drives.size();
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top: testbench for the dual-axis PID controller
// Drives directed edge samples, then tracking-style random samples under a
// series of gain settings, and finally a long wind-up run that pushes both
// integrals into saturation. Both channels idle at random; the checker
// predicts and compares every drive.
// ============================================================================
module tb_top;
  import dapc_pkg::*;

  localparam int IDLE_LIMIT      = 4000;
  localparam int SETTLE_CYCLES   = 300;
  localparam int ITEMS_PER_PHASE = 30;
  localparam int WINDUP_ITEMS    = 2100;
  localparam int UNWIND_ITEMS    = 30;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic [GAIN_W-1:0]    GAIN_MAX     = 24'h7FFFFF;
  localparam logic [GAIN_W-1:0]    GAIN_MIN     = 24'h800000;
  localparam logic [GAIN_W-1:0]    GAIN_ZERO    = 24'h000000;

  logic                 clk;
  logic                 rst;
  logic                 sample_valid;
  logic                 sample_stall;
  sample_t              sample;
  logic                 drive_valid;
  logic                 drive_stall = 1'b0;
  drive_t               drive;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0]    cfg_data;

  int fail_count;
  int pending;
  int idle_cycles;
  int stall_hold;
  bit no_idle;
  int roll_err_walk;
  int pitch_err_walk;

  dual_axis_pid_controller u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .drive_valid  (drive_valid),
    .drive_stall  (drive_stall),
    .drive        (drive),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  pid_drive_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .drive_valid  (drive_valid),
    .drive_stall  (drive_stall),
    .drive        (drive),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the drive channel in runs: mostly short, a few long
  always @(negedge clk) begin
    bit next_stall;
    int r;
    next_stall = drive_stall;
    if (no_idle) begin
      next_stall = 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      next_stall = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 80) stall_hold = $urandom_range(0, 3);
      else if (r < 97) stall_hold = $urandom_range(10, 60);
      else stall_hold = $urandom_range(200, 300);
    end
    drive_stall <= next_stall;
  end

  // End the run when no channel moves for too long
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (drive_valid && !drive_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 8);
    if (r < 96) return $urandom_range(20, 150);
    return $urandom_range(200, 400);
  endfunction

  function automatic logic [DT_W-1:0] pick_elapsed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 15) return DT_W'($urandom_range(1, 16));
    if (r < 90) return DT_W'($urandom_range(200, 20000));
    if (r < 97) return DT_W'($urandom());
    return '1;
  endfunction

  function automatic logic [ANGLE_WIDTH-1:0] edge_angle();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
      1: return {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
      2: return '0;
      3: return '1;
      4: return ANGLE_WIDTH'(1);
      default: return ANGLE_WIDTH'($urandom());
    endcase
  endfunction

  // Let a tracking error drift slowly so the derivative stays moderate
  function automatic int wander(input int v);
    int n;
    n = v + int'($urandom_range(0, 200)) - 100;
    if (n > 6000) n = 6000;
    if (n < -6000) n = -6000;
    return n;
  endfunction

  function automatic logic [GAIN_W-1:0] small_gain(input int span);
    return GAIN_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Mostly tracking samples, then full-range noise and edge values
  function automatic sample_t random_sample();
    sample_t s;
    int      r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      roll_err_walk  = wander(roll_err_walk);
      pitch_err_walk = wander(pitch_err_walk);
      s.roll_target  = ANGLE_WIDTH'(int'($urandom_range(0, 30000)) - 15000);
      s.pitch_target = ANGLE_WIDTH'(int'($urandom_range(0, 30000)) - 15000);
      s.roll_angle   = ANGLE_WIDTH'(int'($signed(s.roll_target)) - roll_err_walk);
      s.pitch_angle  = ANGLE_WIDTH'(int'($signed(s.pitch_target)) - pitch_err_walk);
    end else if (r < 80) begin
      s.roll_angle   = ANGLE_WIDTH'($urandom());
      s.pitch_angle  = ANGLE_WIDTH'($urandom());
      s.roll_target  = ANGLE_WIDTH'($urandom());
      s.pitch_target = ANGLE_WIDTH'($urandom());
    end else begin
      s.roll_angle   = edge_angle();
      s.pitch_angle  = edge_angle();
      s.roll_target  = edge_angle();
      s.pitch_target = edge_angle();
    end
    s.delta_us = pick_elapsed();
    return s;
  endfunction

  // Present one request, hold it until taken, then maybe idle
  task automatic push_sample(input sample_t s);
    int gap;
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (sample_stall);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_angles(input int ra, input int pa, input int rt, input int pt,
                             input int dt);
    sample_t s;
    s.roll_angle   = ANGLE_WIDTH'(ra);
    s.pitch_angle  = ANGLE_WIDTH'(pa);
    s.roll_target  = ANGLE_WIDTH'(rt);
    s.pitch_target = ANGLE_WIDTH'(pt);
    s.delta_us     = DT_W'(dt);
    push_sample(s);
  endtask

  // Wait until every predicted drive has come out
  task automatic drain_drives();
    sample_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic load_gains(input logic [GAIN_W-1:0] rkp, input logic [GAIN_W-1:0] rki,
                            input logic [GAIN_W-1:0] rkd, input logic [GAIN_W-1:0] pkp,
                            input logic [GAIN_W-1:0] pki, input logic [GAIN_W-1:0] pkd,
                            input bit with_spare);
    drain_drives();
    write_gain(CFG_ROLL_KP, rkp);
    write_gain(CFG_ROLL_KI, rki);
    write_gain(CFG_ROLL_KD, rkd);
    write_gain(CFG_PITCH_KP, pkp);
    write_gain(CFG_PITCH_KI, pki);
    write_gain(CFG_PITCH_KD, pkd);
    if (with_spare) begin
      write_gain(CFG_SPARE_LO, GAIN_W'($urandom()));
      write_gain(CFG_SPARE_HI, GAIN_W'($urandom()));
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst            = 1'b1;
    sample_valid   = 1'b0;
    sample         = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    no_idle        = 1'b1;
    roll_err_walk  = 0;
    pitch_err_walk = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Edge samples under reset gains
    send_angles(0, 0, 0, 0, 0);
    send_angles(-32768, 32767, 32767, -32768, 1000);
    send_angles(32767, -32768, -32768, 32767, 1);
    send_angles(0, 0, 256, -256, 0);
    send_angles(0, 0, 256, -256, 1048575);
    send_angles(100, -100, 100, -100, 1000);
    send_angles(-1, 1, 0, 0, 500);
    send_angles(0, 0, 11520, -11520, 0);
    send_angles(0, 0, 11521, -11521, 0);
    send_angles(0, 0, -11520, 11520, 20000);
    send_angles(32767, 32767, 32767, 32767, 1048575);
    send_angles(-32768, -32768, -32768, -32768, 1);
    send_angles(1000, 2000, 1200, 1800, 1000);
    send_angles(0, 0, 0, 0, 1048575);
    send_angles(12345, -12345, -12345, 12345, 0);
    send_angles(-32768, -32768, 32767, 32767, 1);

    // Random samples under a series of gain settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: load_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, 1'b0);
        2: load_gains(GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, 1'b0);
        3: load_gains(GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO,
                      1'b0);
        4: load_gains(GAIN_W'($urandom()), GAIN_W'($urandom()), GAIN_W'($urandom()),
                      GAIN_W'($urandom()), GAIN_W'($urandom()), GAIN_W'($urandom()), 1'b0);
        5: load_gains(small_gain(131072), small_gain(20000), small_gain(8000),
                      small_gain(131072), small_gain(20000), small_gain(8000), 1'b0);
        6: load_gains(GAIN_MIN, GAIN_MAX, GAIN_ZERO, GAIN_MAX, GAIN_MIN,
                      GAIN_W'($urandom()), 1'b0);
        7: load_gains(small_gain(131072), small_gain(20000), small_gain(8000),
                      small_gain(131072), small_gain(20000), small_gain(8000), 1'b1);
        default: ;
      endcase
      no_idle <= ($urandom_range(0, 3) == 0);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) push_sample(random_sample());
    end

    // Wind both integrals into opposite saturation, then back off roll
    load_gains(GAIN_ZERO, GAIN_W'(4), GAIN_ZERO, GAIN_ZERO, GAIN_W'(4), GAIN_ZERO, 1'b0);
    no_idle <= 1'b1;
    for (int k = 0; k < WINDUP_ITEMS; k++)
      send_angles(-32768, 32767, 32767, -32768, 1048575 - $urandom_range(0, 255));
    for (int k = 0; k < UNWIND_ITEMS; k++)
      send_angles(32767, 32767, -32768, -32768, 1048575);

    // Drain, let the block settle and give the verdict
    sample_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/dapc_pkg.sv
rtl/core/dapc_divider.sv
rtl/core/dual_axis_pid_controller.sv
dv/pid_drive_checker.sv
dv/tb_top.sv
